// ----- sv/aerr_pkg.sv -----
`timescale 1ns / 1ps

package aerr_pkg;

  // Input transaction kinds
  typedef enum logic [1:0] {
    MODE_BYTE   = 2'd0,
    MODE_TICK   = 2'd1,
    MODE_START  = 2'd2,
    MODE_CANCEL = 2'd3
  } mode_e;

  // Result event codes
  typedef enum logic [3:0] {
    EV_NONE      = 4'd0,
    EV_PROGRESS  = 4'd1,
    EV_ENROLLED  = 4'd2,
    EV_RETRY     = 4'd3,
    EV_ERROR     = 4'd4,
    EV_NON_ACK   = 4'd5,
    EV_TIMEOUT   = 4'd6,
    EV_STARTED   = 4'd7,
    EV_REJECTED  = 4'd8,
    EV_CANCELLED = 4'd9
  } event_e;

  // Register indexes
  localparam logic REG_TIMEOUT = 1'b0;

  localparam int unsigned TimeoutW = 20;
  localparam logic [TimeoutW-1:0] TimeoutReset = 20'd90000;

  // Frame bytes and codes
  localparam logic [7:0] HDR_HI        = 8'hEF;
  localparam logic [7:0] HDR_LO        = 8'h01;
  localparam logic [7:0] PKT_ACK       = 8'h07;
  localparam logic [7:0] CODE_OK       = 8'h00;
  localparam logic [7:0] CODE_FEATURE  = 8'h07;
  localparam logic [7:0] STEP_STORE    = 8'h06;
  localparam logic [7:0] STEP_FEATURE  = 8'h02;
  localparam logic [7:0] PARAM_STORED  = 8'hF2;

  // Byte positions within a frame
  localparam logic [7:0] POS_HDR_HI = 8'd0;
  localparam logic [7:0] POS_HDR_LO = 8'd1;
  localparam logic [7:0] POS_TYPE   = 8'd6;
  localparam logic [7:0] POS_LEN_HI = 8'd7;
  localparam logic [7:0] POS_LEN_LO = 8'd8;
  localparam logic [7:0] POS_CODE   = 8'd9;
  localparam logic [7:0] POS_STEP   = 8'd10;
  localparam logic [7:0] POS_PARAM  = 8'd11;

  // Frame overhead beyond the length field, and shortest accepted frame
  localparam int unsigned FrameOverhead = 9;
  localparam int unsigned MinFrame      = 12;

endpackage

// ----- sv/auto_enroll_response_receiver_top.sv -----
`timescale 1ns / 1ps

// Auto-enroll response receiver for a fingerprint module. Each input
// transaction is a received UART byte, a 1 ms tick, a session start or a
// cancel; each one yields exactly one result transaction with the event code,
// the confirmation/step/parameter bytes of a completed frame, the template ID
// and the session flags. Frames are hunted by the EF 01 header, the four
// address bytes are skipped, and frames shorter than 12 bytes or longer than
// BUF_DEPTH are dropped; the checksum is not checked. One transaction is
// taken every cycle: the parser state and the result register update in the
// same cycle the transaction is accepted, and the result register with its
// valid flag decouples the output side, so input is only held off while a
// result waits and the output is stalled. The session timeout (in ticks) is
// written through the APB port at address 0.

module auto_enroll_response_receiver_top
  import aerr_pkg::*;
#(
  parameter int unsigned BUF_DEPTH = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // input channel
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [1:0]          mode_i,
  input  logic [7:0]          rx_byte_i,
  // result channel
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [3:0]          event_res_o,
  output logic [7:0]          ack_code_o,
  output logic [7:0]          step_code_o,
  output logic [7:0]          step_param_o,
  output logic [15:0]         enrolled_id_o,
  output logic                session_active_o,
  output logic                send_cancel_o,
  // configuration
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  localparam logic [15:0] MaxLen = 16'(BUF_DEPTH - FrameOverhead);
  localparam logic [15:0] MinLen = 16'(MinFrame - FrameOverhead);

  // State registers
  logic [TimeoutW-1:0] timeout_q;
  logic                active_q, active_d;
  logic [7:0]          count_q, count_d;
  logic [7:0]          ptype_q, ptype_d;
  logic [15:0]         flen_q, flen_d;
  logic [7:0]          code_q, code_d;
  logic [7:0]          step_q, step_d;
  logic [7:0]          param_q, param_d;
  logic [15:0]         next_id_q, next_id_d;
  logic [TimeoutW-1:0] ticks_q, ticks_d;

  // Result register
  logic                out_valid_q;
  event_e              ev_q, ev_d;
  logic [7:0]          ack_q, ack_d;
  logic [7:0]          stp_q, stp_d;
  logic [7:0]          prm_q, prm_d;
  logic [15:0]         id_q;
  logic                sact_q;
  logic                cancel_q, cancel_d;

  logic                in_fire;
  logic                cfg_wr;
  logic [7:0]          pos_inc;
  logic [16:0]         total;
  event_e              frame_ev;
  mode_e               mode;

  assign mode       = mode_e'(mode_i);
  assign in_ready_o = ~out_valid_q | out_ready_i;
  assign in_fire    = in_valid_i & in_ready_o;

  // APB access
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;
  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_TIMEOUT) begin
      prdata = {{(32-TimeoutW){1'b0}}, timeout_q};
    end
  end

  // Parse one received byte
  always_comb begin
    ptype_d  = ptype_q;
    flen_d   = flen_q;
    code_d   = code_q;
    step_d   = step_q;
    param_d  = param_q;
    pos_inc  = count_q + 8'd1;
    count_d  = pos_inc;
    frame_ev = EV_NONE;
    total    = '0;
    case (count_q)
      POS_HDR_HI: count_d = (rx_byte_i == HDR_HI) ? 8'd1 : 8'd0;
      POS_HDR_LO: begin
        if (rx_byte_i == HDR_LO) begin
          count_d = 8'd2;
        end else begin
          count_d = (rx_byte_i == HDR_HI) ? 8'd1 : 8'd0;
        end
      end
      POS_TYPE:   ptype_d = rx_byte_i;
      POS_LEN_HI: flen_d  = {rx_byte_i, flen_q[7:0]};
      POS_LEN_LO: flen_d  = {flen_q[15:8], rx_byte_i};
      POS_CODE:   code_d  = rx_byte_i;
      POS_STEP:   step_d  = rx_byte_i;
      POS_PARAM:  param_d = rx_byte_i;
      default: ;
    endcase
    // check length and completion once the length is known
    if (count_q >= POS_LEN_LO) begin
      total = {1'b0, flen_d} + 17'(FrameOverhead);
      if (flen_d < MinLen || flen_d > MaxLen) begin
        count_d = 8'd0;
      end else if ({9'd0, pos_inc} >= total) begin
        count_d = 8'd0;
        if (ptype_d != PKT_ACK) begin
          frame_ev = EV_NON_ACK;
        end else if (code_d == CODE_OK && step_d == STEP_STORE &&
                     param_d == PARAM_STORED) begin
          frame_ev = EV_ENROLLED;
        end else if (code_d != CODE_OK) begin
          frame_ev = (code_d == CODE_FEATURE && step_d == STEP_FEATURE) ?
                     EV_RETRY : EV_ERROR;
        end else begin
          frame_ev = EV_PROGRESS;
        end
      end
    end
  end

  // Session control and result
  always_comb begin
    active_d  = active_q;
    ticks_d   = ticks_q;
    next_id_d = next_id_q;
    ev_d      = EV_NONE;
    cancel_d  = 1'b0;
    ack_d     = '0;
    stp_d     = '0;
    prm_d     = '0;
    case (mode)
      MODE_BYTE: begin
        if (active_q) begin
          ev_d = frame_ev;
          if (frame_ev != EV_NONE) begin
            ack_d = code_d;
            stp_d = step_d;
            prm_d = param_d;
          end
          if (frame_ev == EV_ENROLLED || frame_ev == EV_ERROR) begin
            active_d = 1'b0;
            ticks_d  = '0;
            cancel_d = 1'b1;
          end
          if (frame_ev == EV_ENROLLED) begin
            next_id_d = next_id_q + 16'd1;
          end
        end
      end
      MODE_TICK: begin
        if (active_q) begin
          if (ticks_q <= TimeoutW'(1)) begin
            active_d = 1'b0;
            ticks_d  = '0;
            ev_d     = EV_TIMEOUT;
            cancel_d = 1'b1;
          end else begin
            ticks_d = ticks_q - TimeoutW'(1);
          end
        end
      end
      MODE_START: begin
        if (active_q) begin
          ev_d = EV_REJECTED;
        end else begin
          active_d = 1'b1;
          ticks_d  = timeout_q;
          ev_d     = EV_STARTED;
        end
      end
      MODE_CANCEL: begin
        active_d = 1'b0;
        ticks_d  = '0;
        ev_d     = EV_CANCELLED;
        cancel_d = 1'b1;
      end
      default: ;
    endcase
  end

  // Configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= TimeoutReset;
    end else if (cfg_wr && paddr[2] == REG_TIMEOUT) begin
      timeout_q <= pwdata[TimeoutW-1:0];
    end
  end

  // Advance session and parser state on each accepted transaction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q  <= 1'b0;
      count_q   <= '0;
      ptype_q   <= '0;
      flen_q    <= '0;
      code_q    <= '0;
      step_q    <= '0;
      param_q   <= '0;
      next_id_q <= '0;
      ticks_q   <= '0;
    end else if (in_fire) begin
      active_q  <= active_d;
      next_id_q <= next_id_d;
      ticks_q   <= ticks_d;
      if (mode == MODE_BYTE && active_q) begin
        ptype_q <= ptype_d;
        flen_q  <= flen_d;
        code_q  <= code_d;
        step_q  <= step_d;
        param_q <= param_d;
        count_q <= (active_d) ? count_d : 8'd0;
      end else if (mode != MODE_BYTE && !(mode == MODE_START && active_q)) begin
        // start, cancel and timeout all restart the header hunt
        if (mode != MODE_TICK || !active_d) begin
          count_q <= 8'd0;
        end
      end
    end
  end

  // Hold the result until the transaction is taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      ev_q     <= ev_d;
      ack_q    <= ack_d;
      stp_q    <= stp_d;
      prm_q    <= prm_d;
      id_q     <= next_id_q;
      sact_q   <= active_d;
      cancel_q <= cancel_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign event_res_o      = ev_q;
  assign ack_code_o       = ack_q;
  assign step_code_o      = stp_q;
  assign step_param_o     = prm_q;
  assign enrolled_id_o    = id_q;
  assign session_active_o = sact_q;
  assign send_cancel_o    = cancel_q;

endmodule

// ----- sim/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
  import aerr_pkg::*;

  localparam int unsigned BufDepth = 64;
  localparam int unsigned MaxLen   = BufDepth - FrameOverhead;

  typedef struct {
    event_e      ev;
    logic [7:0]  ack;
    logic [7:0]  stp;
    logic [7:0]  prm;
    logic [15:0] id;
    logic        act;
    logic        cxl;
  } enroll_result_t;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_ready_o;
  logic [1:0]  mode_i      = MODE_TICK;
  logic [7:0]  rx_byte_i   = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [3:0]  event_res_o;
  logic [7:0]  ack_code_o;
  logic [7:0]  step_code_o;
  logic [7:0]  step_param_o;
  logic [15:0] enrolled_id_o;
  logic        session_active_o;
  logic        send_cancel_o;
  logic        psel        = 1'b0;
  logic        penable     = 1'b0;
  logic        pwrite      = 1'b0;
  logic [2:0]  paddr       = '0;
  logic [31:0] pwdata      = '0;
  logic [31:0] prdata;
  logic        pready;

  // Session and parser state of the predictor
  logic        st_active   = 1'b0;
  logic [7:0]  st_count    = '0;
  logic [7:0]  st_type     = '0;
  logic [15:0] st_len      = '0;
  logic [7:0]  st_code     = '0;
  logic [7:0]  st_step     = '0;
  logic [7:0]  st_param    = '0;
  logic [15:0] st_next_id  = '0;
  logic [19:0] st_ticks    = '0;
  logic [19:0] cfg_timeout = TimeoutReset;

  enroll_result_t pending_results[$];
  int unsigned    err_cnt       = 0;
  int unsigned    items_sent    = 0;
  int unsigned    results_seen  = 0;
  int unsigned    ev_seen[10];
  bit             in_idle_on    = 1'b1;
  bit             out_stall_on  = 1'b1;
  int unsigned    out_stall_left = 0;

  auto_enroll_response_receiver_top #(
    .BUF_DEPTH(BufDepth)
  ) dut (.*);

  always #1 clk_i = ~clk_i;

  // Gap length: mostly short, now and then long
  function automatic int unsigned pick_idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 75) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 8);
    return $urandom_range(12, 30);
  endfunction

  function automatic logic [7:0] rand_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic void close_session();
    st_active = 1'b0;
    st_count  = '0;
    st_ticks  = '0;
  endfunction

  // Advance the frame parser by one byte; return the frame event, if any
  function automatic event_e parse_byte(input logic [7:0] b);
    int unsigned total;
    logic [7:0]  pos;
    pos = st_count;
    if (pos == POS_HDR_HI) begin
      st_count = (b == HDR_HI) ? 8'd1 : 8'd0;
      return EV_NONE;
    end
    if (pos == POS_HDR_LO) begin
      if (b == HDR_LO) st_count = 8'd2;
      else st_count = (b == HDR_HI) ? 8'd1 : 8'd0;
      return EV_NONE;
    end
    case (pos)
      POS_TYPE:   st_type = b;
      POS_LEN_HI: st_len[15:8] = b;
      POS_LEN_LO: st_len[7:0] = b;
      POS_CODE:   st_code = b;
      POS_STEP:   st_step = b;
      POS_PARAM:  st_param = b;
      default: ;
    endcase
    st_count = pos + 8'd1;
    if (pos < POS_LEN_LO) return EV_NONE;
    total = st_len + FrameOverhead;
    // drop frames of impossible length and resume the hunt
    if (total < MinFrame || total > BufDepth) begin
      st_count = '0;
      return EV_NONE;
    end
    if (st_count < total) return EV_NONE;
    st_count = '0;
    if (st_type != PKT_ACK) return EV_NON_ACK;
    if (st_code == CODE_OK && st_step == STEP_STORE && st_param == PARAM_STORED)
      return EV_ENROLLED;
    if (st_code != CODE_OK)
      return (st_code == CODE_FEATURE && st_step == STEP_FEATURE) ? EV_RETRY : EV_ERROR;
    return EV_PROGRESS;
  endfunction

  // Compute the result of one input transaction and update the session state
  function automatic enroll_result_t predict_result(input mode_e m, input logic [7:0] b);
    enroll_result_t r;
    logic           frame_done;
    r.ev       = EV_NONE;
    r.cxl      = 1'b0;
    frame_done = 1'b0;
    case (m)
      MODE_BYTE: begin
        if (st_active) begin
          r.ev       = parse_byte(b);
          frame_done = (r.ev != EV_NONE);
        end
      end
      MODE_TICK: begin
        if (st_active) begin
          if (st_ticks <= 20'd1) begin
            close_session();
            r.ev  = EV_TIMEOUT;
            r.cxl = 1'b1;
          end else begin
            st_ticks--;
          end
        end
      end
      MODE_START: begin
        if (st_active) begin
          r.ev = EV_REJECTED;
        end else begin
          st_active = 1'b1;
          st_count  = '0;
          st_ticks  = cfg_timeout;
          r.ev      = EV_STARTED;
        end
      end
      MODE_CANCEL: begin
        close_session();
        r.ev  = EV_CANCELLED;
        r.cxl = 1'b1;
      end
      default: ;
    endcase
    r.id = st_next_id;
    if (r.ev == EV_ENROLLED) begin
      st_next_id++;
      close_session();
      r.cxl = 1'b1;
    end else if (r.ev == EV_ERROR) begin
      close_session();
      r.cxl = 1'b1;
    end
    r.ack = frame_done ? st_code : 8'd0;
    r.stp = frame_done ? st_step : 8'd0;
    r.prm = frame_done ? st_param : 8'd0;
    r.act = st_active;
    return r;
  endfunction

  // Hold valid until accepted, record the expected result, then maybe idle
  task automatic send_item(input mode_e m, input logic [7:0] b);
    int unsigned gap;
    mode_i     <= m;
    rx_byte_i  <= b;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    pending_results.push_back(predict_result(m, b));
    items_sent++;
    gap = (in_idle_on && $urandom_range(0, 2) == 0) ? pick_idle_len() : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Drop valid and wait until every expected result has been checked
  task automatic wait_results_done();
    in_valid_i <= 1'b0;
    wait (pending_results.size() == 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_timeout(input logic [19:0] ticks);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_TIMEOUT, 2'b00};
    pwdata  <= 32'(ticks);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    cfg_timeout = ticks;
  endtask

  // Send a response frame; a bad length stops after the length bytes
  task automatic send_frame(input logic [7:0] ptype, input logic [15:0] len,
                            input logic [7:0] code, input logic [7:0] stp,
                            input logic [7:0] prm, input int unsigned cut = 255);
    int unsigned total;
    int unsigned n;
    logic [7:0]  b;
    total = len + FrameOverhead;
    n = (total < MinFrame || total > BufDepth) ? POS_CODE : total;
    if (cut < n) n = cut;
    for (int unsigned i = 0; i < n; i++) begin
      case (i)
        POS_HDR_HI: b = HDR_HI;
        POS_HDR_LO: b = HDR_LO;
        POS_TYPE:   b = ptype;
        POS_LEN_HI: b = len[15:8];
        POS_LEN_LO: b = len[7:0];
        POS_CODE:   b = code;
        POS_STEP:   b = stp;
        POS_PARAM:  b = prm;
        default:    b = rand_byte();
      endcase
      send_item(MODE_BYTE, b);
    end
  endtask

  task automatic ensure_session();
    if (!st_active) send_item(MODE_START, rand_byte());
  endtask

  // Frame with random content, weighted toward the interesting codes
  task automatic send_random_frame();
    logic [7:0]  ptype, code, stp, prm;
    logic [15:0] len;
    int unsigned k, cut;
    ptype = ($urandom_range(0, 7) == 0) ? rand_byte() : PKT_ACK;
    k = $urandom_range(0, 99);
    if (k < 60) len = 16'(MinFrame - FrameOverhead + $urandom_range(0, 3));
    else if (k < 75) len = 16'($urandom_range(MinFrame - FrameOverhead, MaxLen));
    else if (k < 82) len = 16'(MaxLen);
    else if (k < 91) len = 16'($urandom_range(0, MinFrame - FrameOverhead - 1));
    else len = 16'($urandom_range(MaxLen + 1, 16'hFFFF));
    k = $urandom_range(0, 99);
    code = (k < 40) ? CODE_OK : (k < 65) ? CODE_FEATURE : rand_byte();
    k = $urandom_range(0, 99);
    stp = (k < 35) ? STEP_STORE : (k < 65) ? STEP_FEATURE : rand_byte();
    prm = ($urandom_range(0, 99) < 45) ? PARAM_STORED : rand_byte();
    cut = ($urandom_range(0, 11) == 0) ? $urandom_range(1, 20) : 255;
    // lone header byte or noise ahead of the frame
    if ($urandom_range(0, 9) == 0) send_item(MODE_BYTE, HDR_HI);
    if ($urandom_range(0, 9) == 0) send_item(MODE_BYTE, rand_byte());
    send_frame(ptype, len, code, stp, prm, cut);
  endtask

  task automatic test_session_control();
    send_item(MODE_TICK, rand_byte());
    send_item(MODE_BYTE, HDR_HI);
    send_item(MODE_CANCEL, rand_byte());
    send_item(MODE_START, 8'h00);
    send_item(MODE_START, 8'hFF);
    send_item(MODE_TICK, rand_byte());
    send_item(MODE_CANCEL, rand_byte());
    send_item(MODE_START, rand_byte());
  endtask

  task automatic test_header_hunt();
    ensure_session();
    // repeated header start byte, then a full frame
    send_item(MODE_BYTE, 8'h00);
    send_item(MODE_BYTE, HDR_HI);
    send_frame(PKT_ACK, 16'd3, CODE_OK, 8'h01, 8'h01);
    // broken header, then a full frame
    send_item(MODE_BYTE, HDR_HI);
    send_item(MODE_BYTE, 8'h02);
    send_frame(PKT_ACK, 16'd3, CODE_OK, 8'h02, 8'h02);
  endtask

  task automatic test_frame_classes();
    ensure_session();
    send_frame(PKT_ACK, 16'd3, CODE_OK, 8'h00, 8'h00);
    send_frame(PKT_ACK, 16'd3, CODE_FEATURE, STEP_FEATURE, 8'hFF);
    send_frame(8'hFF, 16'd3, CODE_OK, STEP_STORE, PARAM_STORED);
    send_frame(PKT_ACK, 16'd3, CODE_OK, STEP_STORE, PARAM_STORED);
    ensure_session();
    send_frame(PKT_ACK, 16'd3, 8'hFF, 8'hFF, 8'hFF);
    ensure_session();
  endtask

  task automatic test_frame_length();
    ensure_session();
    send_frame(PKT_ACK, 16'(MinFrame - FrameOverhead - 1), CODE_OK, 8'h01, 8'h01);
    send_frame(PKT_ACK, 16'(MaxLen), CODE_OK, 8'h03, 8'h04);
    send_frame(PKT_ACK, 16'(MaxLen + 1), CODE_OK, 8'h01, 8'h01);
    send_frame(PKT_ACK, 16'hFFFF, CODE_OK, 8'h01, 8'h01);
    send_frame(PKT_ACK, 16'd3, CODE_OK, 8'h05, 8'h06);
  endtask

  task automatic test_timeout();
    wait_results_done();
    write_timeout(20'd1);
    ensure_session();
    send_item(MODE_TICK, rand_byte());
    wait_results_done();
    write_timeout(20'd3);
    send_item(MODE_START, rand_byte());
    repeat (3) send_item(MODE_TICK, rand_byte());
    send_item(MODE_START, rand_byte());
    send_item(MODE_TICK, rand_byte());
    send_item(MODE_CANCEL, rand_byte());
  endtask

  // Random traffic over several timeout settings, extremes included
  task automatic test_random_traffic();
    int unsigned phase_ticks[6];
    int unsigned stop_at;
    int unsigned r;
    phase_ticks = '{20'hFFFFF, 1, 40, 9, 250, TimeoutReset};
    foreach (phase_ticks[p]) begin
      wait_results_done();
      write_timeout(20'(phase_ticks[p]));
      stop_at = items_sent + 135;
      while (items_sent < stop_at) begin
        if ($urandom_range(0, 59) == 0) begin
          in_idle_on   = ($urandom_range(0, 9) < 7);
          out_stall_on = ($urandom_range(0, 9) < 7);
        end
        if (!st_active && $urandom_range(0, 9) != 0) begin
          send_item(MODE_START, rand_byte());
        end else begin
          r = $urandom_range(0, 99);
          if (r < 55) send_random_frame();
          else if (r < 65) repeat ($urandom_range(1, 4)) send_item(MODE_BYTE, rand_byte());
          else if (r < 85) repeat ($urandom_range(1, 6)) send_item(MODE_TICK, rand_byte());
          else if (r < 92) send_item(MODE_START, rand_byte());
          else if (r < 96) send_item(MODE_CANCEL, rand_byte());
          else begin
            send_item(MODE_BYTE, HDR_HI);
            send_item(MODE_BYTE, $urandom_range(0, 1) ? HDR_HI : rand_byte());
          end
        end
      end
    end
    in_idle_on   = 1'b1;
    out_stall_on = 1'b1;
  endtask

  // Stall the result channel at random
  always @(posedge clk_i) begin
    if (out_stall_left > 0) begin
      out_stall_left--;
      out_ready_i <= 1'b0;
    end else if (out_stall_on && $urandom_range(0, 3) == 0) begin
      out_stall_left = pick_idle_len() - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  function automatic void compare_field(input string name, input int unsigned want,
                                        input int unsigned got);
    if (want != got) begin
      err_cnt++;
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
    end
  endfunction

  // Check each result transaction against the oldest expectation
  always @(posedge clk_i) begin : result_check
    enroll_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        err_cnt++;
        $display("%0t: unexpected result, expected none actual event %0d",
                 $time, event_res_o);
      end else begin
        want = pending_results.pop_front();
        compare_field("event_res", want.ev, event_res_o);
        compare_field("ack_code", want.ack, ack_code_o);
        compare_field("step_code", want.stp, step_code_o);
        compare_field("step_param", want.prm, step_param_o);
        compare_field("enrolled_id", want.id, enrolled_id_o);
        compare_field("session_active", want.act, session_active_o);
        compare_field("send_cancel", want.cxl, send_cancel_o);
        results_seen++;
        ev_seen[want.ev]++;
      end
    end
  end

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_session_control();
    test_header_hunt();
    test_frame_classes();
    test_frame_length();
    test_timeout();
    test_random_traffic();
    wait_results_done();
    repeat (10) @(posedge clk_i);
    $display("Run covered %0d input transactions and %0d checked results.",
             items_sent, results_seen);
    $display("Events: progress %0d, enrolled %0d, retry %0d, error %0d, non-ack %0d, timeout %0d",
             ev_seen[EV_PROGRESS], ev_seen[EV_ENROLLED], ev_seen[EV_RETRY],
             ev_seen[EV_ERROR], ev_seen[EV_NON_ACK], ev_seen[EV_TIMEOUT]);
    if (err_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #1000000;
    $display("%0t: timeout, %0d results still pending", $time, pending_results.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
